FILE: hdl/csq_pkg.sv
// Shared types and constants for the counting semaphore with wait queue.
`default_nettype none
package csq_pkg;

  localparam int CountW = 16;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOWAIT = 3'd1,
    ST_QUEUED = 3'd2,
    ST_ATMAX  = 3'd3,
    ST_QFULL  = 3'd4
  } status_t;

  // Request operation codes
  typedef enum logic {
    FUNC_TAKE = 1'b0,
    FUNC_GIVE = 1'b1
  } func_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_LIMIT   = 1'b0,
    CFG_PRELOAD = 1'b1
  } cfg_idx_t;

  // Per-cell control of the wait queue chain
  typedef struct packed {
    logic shift;  // take the neighbor's entry (dequeue)
    logic load;   // capture the incoming task id (enqueue)
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/csq_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface csq_req_if #(parameter int TASK_ID_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [TASK_ID_BITS-1:0] task_id;
  logic                    wait_allowed;
  modport source (output valid, func, task_id, wait_allowed, input ready);
  modport sink   (input valid, func, task_id, wait_allowed, output ready);
endinterface

interface csq_rsp_if #(parameter int TASK_ID_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic                    wake_valid;
  logic [TASK_ID_BITS-1:0] wake_task;
  modport source (output valid, status, wake_valid, wake_task, input ready);
  modport sink   (input valid, status, wake_valid, wake_task, output ready);
endinterface
`default_nettype wire

FILE: hdl/csq_cell.sv
// One wait queue cell: holds a task id, shifts toward the head or loads a new id.
`default_nettype none
module csq_cell
  import csq_pkg::*;
#(
  parameter int TASK_ID_BITS = 8
) (
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic [TASK_ID_BITS-1:0] nbr_id,
  input  wire logic [TASK_ID_BITS-1:0] new_id,
  output logic      [TASK_ID_BITS-1:0] id
);

  logic [TASK_ID_BITS-1:0] id_r;
  logic [TASK_ID_BITS-1:0] id_nxt;

  always_comb begin
    id_nxt = id_r;
    if (ctl.shift) begin
      id_nxt = nbr_id;
    end else if (ctl.load) begin
      id_nxt = new_id;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id = id_r;

endmodule
`default_nettype wire

FILE: hdl/csq_queue.sv
// FIFO of waiting task ids built as a chain of cells; head sits in cell 0.
`default_nettype none
module csq_queue
  import csq_pkg::*;
#(
  parameter int WAIT_DEPTH   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    enq,
  input  wire logic                    deq,
  input  wire logic [TASK_ID_BITS-1:0] enq_id,
  output logic                         full,
  output logic                         empty,
  output logic      [TASK_ID_BITS-1:0] head_id
);

  localparam int CntW = $clog2(WAIT_DEPTH + 1);

  logic [CntW-1:0]         total_r;
  logic [CntW-1:0]         total_nxt;
  logic [TASK_ID_BITS-1:0] ids [WAIT_DEPTH];

  assign full    = (total_r == CntW'(WAIT_DEPTH));
  assign empty   = (total_r == '0);
  assign head_id = ids[0];

  // Fill count; enqueue and dequeue never coincide
  always_comb begin
    total_nxt = total_r;
    if (enq && !full) begin
      total_nxt = total_r + CntW'(1);
    end else if (deq && !empty) begin
      total_nxt = total_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Cell chain: on dequeue every cell takes its upper neighbor's entry; the last keeps its own
  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    cell_ctl_t               ctl;
    logic [TASK_ID_BITS-1:0] nbr;

    assign ctl.shift = deq && !empty;
    assign ctl.load  = enq && !full && (total_r == CntW'(i));

    if (i == WAIT_DEPTH - 1) begin : g_last
      assign nbr = ids[i];
    end else begin : g_mid
      assign nbr = ids[i+1];
    end

    csq_cell #(
      .TASK_ID_BITS (TASK_ID_BITS)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .nbr_id (nbr),
      .new_id (enq_id),
      .id     (ids[i])
    );
  end

endmodule
`default_nettype wire

FILE: hdl/counting_semaphore_wait_queue.sv
// Counting semaphore with a FIFO wait queue of task ids.
//
// Usage:
//   in_ch  : requests (func 0 take, 1 give; task_id and wait_allowed for takes).
//   out_ch : one result per request: status, wake_valid, wake_task.
//   cfg_*  : register 0 count limit, register 1 preload count; writing the preload
//            loads the count. Write only while no request is in flight.
// Timing: the result appears in the cycle after the request transfer, held in an
//   output register. Throughput: one request per cycle unless stalled; the count
//   and the queue ends are updated in the accept cycle; a dequeue shifts one cell.
// Stall: while the output register holds an untaken result, in_ch.ready drops;
//   a request is accepted in the same cycle the waiting result is taken.
// Reset: count 0, count limit 1, wait queue empty, no result pending. Queue
//   cells hold no reset value; only filled cells are read.
`default_nettype none
module counting_semaphore_wait_queue
  import csq_pkg::*;
#(
  parameter int WAIT_DEPTH   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  csq_req_if.sink                in_ch,
  csq_rsp_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [CountW-1:0] cfg_data
);

  logic [CountW-1:0] limit_r;
  logic [CountW-1:0] sem_count_r;
  logic [CountW-1:0] sem_count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           status_r;
  status_t           status_nxt;
  logic              wake_valid_r;
  logic              wake_valid_nxt;
  logic [TASK_ID_BITS-1:0] wake_task_r;
  logic [TASK_ID_BITS-1:0] wake_task_nxt;

  logic fire;
  logic enq;
  logic deq;
  logic q_full;
  logic q_empty;
  logic [TASK_ID_BITS-1:0] head_id;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // Request decode and semaphore update
  always_comb begin
    sem_count_nxt  = sem_count_r;
    status_nxt     = status_r;
    wake_valid_nxt = wake_valid_r;
    wake_task_nxt  = wake_task_r;
    enq            = 1'b0;
    deq            = 1'b0;
    if (fire) begin
      status_nxt     = ST_OK;
      wake_valid_nxt = 1'b0;
      wake_task_nxt  = '0;
      if (func_t'(in_ch.func) == FUNC_TAKE) begin
        if (sem_count_r != '0) begin
          sem_count_nxt = sem_count_r - CountW'(1);
        end else if (!in_ch.wait_allowed) begin
          status_nxt = ST_NOWAIT;
        end else if (q_full) begin
          status_nxt = ST_QFULL;
        end else begin
          enq        = 1'b1;
          status_nxt = ST_QUEUED;
        end
      end else begin
        if (sem_count_r >= limit_r) begin
          status_nxt = ST_ATMAX;
        end else begin
          sem_count_nxt = sem_count_r + CountW'(1);
          if (!q_empty) begin
            deq            = 1'b1;
            wake_valid_nxt = 1'b1;
            wake_task_nxt  = head_id;
          end
        end
      end
    end
    // Configuration load of the count
    if (cfg_we && cfg_idx_t'(cfg_idx) == CFG_PRELOAD) begin
      sem_count_nxt = cfg_data;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= CountW'(1);
      sem_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sem_count_r <= sem_count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx_t'(cfg_idx) == CFG_LIMIT) begin
        limit_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    wake_valid_r <= wake_valid_nxt;
    wake_task_r  <= wake_task_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.wake_valid = wake_valid_r;
  assign out_ch.wake_task  = wake_task_r;

  csq_queue #(
    .WAIT_DEPTH   (WAIT_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .deq     (deq),
    .enq_id  (in_ch.task_id),
    .full    (q_full),
    .empty   (q_empty),
    .head_id (head_id)
  );

endmodule
`default_nettype wire
